@@ rtl/svt_pkg.sv @@
// svt_pkg: types, constants and constant tables of the sine voice.
// Used by the sequencer, the top level and the checker.
package svt_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int QTR_SIZE        = 1 << QTR_BITS;
  localparam int MAG_W           = SAMPLE_BITS - 1;
  localparam int LEVEL_FULL      = (3 << (SAMPLE_BITS - 1)) / 20;
  localparam int LVL_W           = $clog2(LEVEL_FULL + 1);
  localparam int SR_W            = 18;
  localparam int SEMI_W          = 25;
  localparam int OCT_W           = 4;
  localparam int NUM_W           = SEMI_W + (1 << OCT_W) - 5;
  localparam int DEN_W           = SR_W + 21;
  localparam int DVD_W           = NUM_W + PHASE_BITS;
  localparam int CNT_W           = $clog2(DVD_W);
  localparam int TAIL_W          = 16;
  localparam int MUL_W           = TAIL_W + 1;

  localparam logic [SR_W-1:0]   SR_RESET    = SR_W'(48000);
  localparam logic [TAIL_W-1:0] TAIL_FULL   = 16'hFFFF;
  localparam logic [TAIL_W-1:0] TAIL_END    = 16'd327;
  localparam logic [TAIL_W-1:0] DECAY_Q16   = 16'd64881;
  localparam logic [63:0]       ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       SINE_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  localparam logic [2:0] ADDR_SAMPLE_RATE = 3'd0;

  localparam logic [1:0] KIND_ON   = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic       allow_tail_off;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          voice_active;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_ON_INIT, OP_DIV, OP_ON_DONE, OP_OFF, OP_SINE,
    OP_MUL_LEVEL, OP_MUL_TAIL, OP_MUL_DECAY, OP_EMIT, OP_EMIT_ZERO
  } op_t;

  typedef enum logic [1:0] {BR_NONE, BR_DIV_MORE, BR_SILENT} br_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_ON   = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV  = 4'd1;
  localparam logic [PC_W-1:0] PC_OFF  = 4'd3;
  localparam logic [PC_W-1:0] PC_TICK = 4'd4;
  localparam logic [PC_W-1:0] PC_ZERO = 4'd9;

  typedef struct packed {
    op_t             op;
    br_t             br;
    logic [PC_W-1:0] target;
    logic            last;
    logic            emit;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic silent;
    logic div_more;
    logic out_hold;
  } stat_t;

  typedef logic [11:0][SEMI_W-1:0] semi_tab_t;
  localparam semi_tab_t SEMI_TAB = {
    25'd32367136, 25'd30550508, 25'd28835840, 25'd27217409,
    25'd25689813, 25'd24247954, 25'd22887021, 25'd21602472,
    25'd20390018, 25'd19245614, 25'd18165441, 25'd17145893
  };

  typedef logic [QTR_SIZE-1:0][MAG_W-1:0] sine_tab_t;
  typedef logic [127:0][LVL_W-1:0]        lvl_tab_t;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // degree-11 odd Taylor series of sin(pi/2*u), u in Q30
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x, x2, s, r;
    x  = mul_q30(u, HALF_PI_Q30);
    x2 = mul_q30(x, x);
    s  = ONE_Q30 - x2 / 110;
    s  = ONE_Q30 - mul_q30(x2 / 72, s);
    s  = ONE_Q30 - mul_q30(x2 / 42, s);
    s  = ONE_Q30 - mul_q30(x2 / 20, s);
    s  = ONE_Q30 - mul_q30(x2 / 6, s);
    s  = mul_q30(x, s);
    r  = (s * SINE_AMP + (ONE_Q30 >> 1)) >> 30;
    return r[MAG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int i = 0; i < QTR_SIZE; i++) begin
      t[i] = quarter_sine(64'(i) << (30 - QTR_BITS));
    end
    return t;
  endfunction

  function automatic lvl_tab_t build_level();
    lvl_tab_t t;
    for (int v = 0; v < 128; v++) begin
      t[v] = LVL_W'((LEVEL_FULL * v) / 127);
    end
    return t;
  endfunction

  localparam sine_tab_t        SINE_TAB  = build_sine();
  localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(ONE_Q30);
  localparam lvl_tab_t         LEVEL_TAB = build_level();

endpackage

@@ rtl/svt_seq.sv @@
// svt_seq: microcode sequencer of the sine voice (program ROM, step counter, jumps).
// Depends on svt_pkg.
module svt_seq import svt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [PC_W-1:0] entry,
  input  stat_t           stat,
  output ctl_t            ctl,
  output logic            busy
);

  function automatic uword_t rom(input logic [PC_W-1:0] a);
    uword_t w;
    w = '{op: OP_NOP, br: BR_NONE, target: '0, last: 1'b1, emit: 1'b0};
    case (a)
      4'd0:    w = '{op: OP_ON_INIT,   br: BR_NONE,     target: '0,      last: 1'b0, emit: 1'b0};
      4'd1:    w = '{op: OP_DIV,       br: BR_DIV_MORE, target: PC_DIV,  last: 1'b0, emit: 1'b0};
      4'd2:    w = '{op: OP_ON_DONE,   br: BR_NONE,     target: '0,      last: 1'b1, emit: 1'b0};
      4'd3:    w = '{op: OP_OFF,       br: BR_NONE,     target: '0,      last: 1'b1, emit: 1'b0};
      4'd4:    w = '{op: OP_SINE,      br: BR_SILENT,   target: PC_ZERO, last: 1'b0, emit: 1'b0};
      4'd5:    w = '{op: OP_MUL_LEVEL, br: BR_NONE,     target: '0,      last: 1'b0, emit: 1'b0};
      4'd6:    w = '{op: OP_MUL_TAIL,  br: BR_NONE,     target: '0,      last: 1'b0, emit: 1'b0};
      4'd7:    w = '{op: OP_MUL_DECAY, br: BR_NONE,     target: '0,      last: 1'b0, emit: 1'b0};
      4'd8:    w = '{op: OP_EMIT,      br: BR_NONE,     target: '0,      last: 1'b1, emit: 1'b1};
      4'd9:    w = '{op: OP_EMIT_ZERO, br: BR_NONE,     target: '0,      last: 1'b1, emit: 1'b1};
      default: w = '{op: OP_NOP,       br: BR_NONE,     target: '0,      last: 1'b1, emit: 1'b0};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc, pc_next;
  logic            busy_next;
  uword_t          word;
  logic            go;
  logic            taken;

  assign word = rom(pc);

  always_comb begin
    go = busy && !(word.emit && stat.out_hold);
    case (word.br)
      BR_DIV_MORE: taken = stat.div_more;
      BR_SILENT:   taken = stat.silent;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        pc_next   = entry;
        busy_next = 1'b1;
      end
    end else if (go) begin
      if (taken) begin
        pc_next = word.target;
      end else if (word.last) begin
        busy_next = 1'b0;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_comb begin
    ctl.op = busy ? word.op : OP_NOP;
    ctl.go = go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

@@ rtl/sine_voice_with_tail_off.sv @@
// sine_voice_with_tail_off: top level; datapath, APB register and output register.
// Depends on svt_pkg and svt_seq.
//
//  channel | signals                         | direction
//  in      | in_valid, in_stall, in_data     | note on / note off / tick items
//  out     | out_valid, out_stall, out_data  | one sample per tick
//  cfg     | psel, penable, pwrite, paddr,   | sample_rate at byte address 0
//          | pwdata, prdata, pready          |
//
// One item at a time. Note on: a bit-per-cycle restoring divider over a 68-bit dividend
// sets the phase step. Note off: arms the release tail or stops the voice. Tick: sine,
// level, tail and decay steps on one shared 17x17 multiplier; a silent voice emits zero.
// An emit step waits while the previous sample is stalled. Reset is synchronous.
module sine_voice_with_tail_off import svt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SR_W-1:0]       sample_rate;
  logic [PHASE_BITS-1:0] phase, phase_step;
  logic [LVL_W-1:0]      note_level;
  logic [TAIL_W-1:0]     tail_gain;
  logic                  tailing;

  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [2*MUL_W-1:0]    prod;
  logic [DEN_W-1:0]      rem;
  logic [DVD_W-1:0]      dvd;
  logic [CNT_W-1:0]      cnt;

  logic                  busy;
  logic                  start;
  logic [PC_W-1:0]       entry;
  ctl_t                  ctl;
  stat_t                 stat;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SAMPLE_RATE) ? 32'(sample_rate) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_SAMPLE_RATE) begin
      sample_rate <= pwdata[SR_W-1:0];
    end
  end

  // input decode
  assign in_stall = busy;

  always_comb begin
    start = in_valid && !busy;
    case (in_data.kind)
      KIND_ON:   entry = PC_ON;
      KIND_OFF:  entry = PC_OFF;
      KIND_TICK: entry = PC_TICK;
      default: begin
        entry = PC_ON;
        start = 1'b0;
      end
    endcase
  end

  assign stat.silent   = (phase_step == '0);
  assign stat.div_more = (cnt != '0);
  assign stat.out_hold = out_valid && out_stall;

  svt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .entry (entry),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // note-on operand setup
  logic [6:0]        note;
  logic [6:0]        vel;
  logic              tail_req;
  logic [14:0]       note_x171;
  logic [OCT_W-1:0]  oct;
  logic [3:0]        semi;
  logic [NUM_W-1:0]  num;
  logic [SR_W-1:0]   sr_eff;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    rs;
  logic              ge;

  // item fields held for the whole sequence
  always_ff @(posedge clk) begin
    if (start) begin
      note     <= in_data.note_number;
      vel      <= in_data.note_velocity;
      tail_req <= in_data.allow_tail_off;
    end
  end

  assign note_x171 = {8'd0, note} * 15'd171;
  assign oct       = OCT_W'(note_x171 >> 11);
  assign semi      = 4'(note - {3'd0, oct} * 7'd12);
  assign num       = NUM_W'(SEMI_TAB[semi]) << oct;
  assign sr_eff    = (sample_rate == '0) ? SR_W'(1) : sample_rate;
  assign den       = {sr_eff, 21'd0};
  assign rs        = {rem, dvd[DVD_W-1]};
  assign ge        = (rs >= {1'b0, den});

  // sine lookup
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QTR_BITS-1:0]        qpos;
  logic [MAG_W-1:0]           sine_mag;

  assign idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign qpos = idx[QTR_BITS-1:0];

  always_comb begin
    if (!idx[QTR_BITS]) begin
      sine_mag = SINE_TAB[qpos];
    end else if (qpos == '0) begin
      sine_mag = SINE_PEAK;
    end else begin
      sine_mag = SINE_TAB[QTR_BITS'(QTR_SIZE - int'(qpos))];
    end
  end

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [TAIL_W-1:0]  tail_dec;
  logic               tail_done;

  always_comb begin
    case (ctl.op)
      OP_MUL_LEVEL: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(note_level);
      end
      OP_MUL_TAIL: begin
        mul_a = MUL_W'(prod[MAG_W +: TAIL_W]);
        mul_b = tailing ? MUL_W'(tail_gain) : (MUL_W'(1) << TAIL_W);
      end
      OP_MUL_DECAY: begin
        mul_a = MUL_W'(tail_gain);
        mul_b = MUL_W'(DECAY_Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign tail_dec  = prod[TAIL_W +: TAIL_W];
  assign tail_done = tailing && (tail_dec <= TAIL_END);

  // datapath state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      note_level <= '0;
      tail_gain  <= '0;
      tailing    <= 1'b0;
    end else if (ctl.go) begin
      case (ctl.op)
        OP_ON_INIT: begin
          phase      <= '0;
          tail_gain  <= '0;
          tailing    <= 1'b0;
          note_level <= LEVEL_TAB[vel];
        end
        OP_ON_DONE: phase_step <= dvd[PHASE_BITS-1:0];
        OP_OFF: begin
          if (tail_req) begin
            if (!tailing) begin
              tailing   <= 1'b1;
              tail_gain <= TAIL_FULL;
            end
          end else begin
            phase_step <= '0;
          end
        end
        OP_EMIT: begin
          phase <= phase + phase_step;
          if (tailing) begin
            tail_gain <= tail_dec;
          end
          if (tail_done) begin
            phase_step <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.op)
        OP_ON_INIT: begin
          rem <= '0;
          dvd <= {num, {PHASE_BITS{1'b0}}};
          cnt <= CNT_W'(DVD_W - 1);
        end
        OP_DIV: begin
          rem <= ge ? DEN_W'(rs - {1'b0, den}) : rs[DEN_W-1:0];
          dvd <= {dvd[DVD_W-2:0], ge};
          cnt <= cnt - 1'b1;
        end
        OP_SINE: begin
          mag <= sine_mag;
          neg <= idx[SINE_TABLE_BITS-1];
        end
        OP_MUL_LEVEL, OP_MUL_TAIL: prod <= mul_a * mul_b;
        OP_MUL_DECAY: begin
          mag  <= prod[TAIL_W +: MAG_W];
          prod <= mul_a * mul_b;
        end
        default: ;
      endcase
    end
  end

  // output register
  logic emit_go;
  assign emit_go = ctl.go && (ctl.op == OP_EMIT || ctl.op == OP_EMIT_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (ctl.op == OP_EMIT) begin
        out_data.sample_out   <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        out_data.voice_active <= !tail_done;
      end else begin
        out_data.sample_out   <= '0;
        out_data.voice_active <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/svt_chk.sv @@
// svt_chk: port-level checker for sine_voice_with_tail_off, bound to the top level.
// Depends on svt_pkg.
module svt_chk import svt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_t         in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_data,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled sample holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // a decoded transfer makes the block busy in the cycle after it
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (in_data.kind == KIND_ON || in_data.kind == KIND_OFF || in_data.kind == KIND_TICK)
    |=> in_stall)
    else $error("no busy cycle after input transfer");

  // a new sample only appears at the end of a sequence
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output without work in progress");

  // a written sample rate reads back
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == ADDR_SAMPLE_RATE
    |=> prdata == (32'h0003FFFF & $past(pwdata)) || paddr != ADDR_SAMPLE_RATE)
    else $error("sample rate readback mismatch");

endmodule

bind sine_voice_with_tail_off svt_chk u_svt_chk (.*);

@@ tb/tb_sine_voice_with_tail_off.sv @@
// tb_sine_voice_with_tail_off: self-checking bench for the sine voice with release tail.
// Drives note on / note off / tick transfers and compares each sample with a local voice
// predictor. Depends on svt_pkg and sine_voice_with_tail_off.
module tb_sine_voice_with_tail_off;
  import svt_pkg::*;

  localparam int          LIMIT_CYCLES  = 600000;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          HOLD_CYCLES   = 800;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam int          LEVEL_Q15     = 4915;
  localparam logic [31:0] DECAY         = 32'd64881;
  localparam logic [15:0] RELEASE_FLOOR = 16'd327;
  localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI   = 64'd1686629713;
  localparam logic [63:0] PEAK          = 64'd32767;
  localparam logic [24:0] SEMI_Q16 [12] = '{
    25'd17145893, 25'd18165441, 25'd19245614, 25'd20390018, 25'd21602472, 25'd22887021,
    25'd24247954, 25'd25689813, 25'd27217409, 25'd28835840, 25'd30550508, 25'd32367136
  };

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  sine_voice_with_tail_off uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predicted voice state
  logic [17:0] rate_hz     = 18'd48000;
  logic [31:0] voice_phase = '0;
  logic [31:0] voice_step  = '0;
  logic [15:0] voice_level = '0;
  logic [15:0] tail_q16    = '0;
  logic        releasing   = 1'b0;

  in_t  item_feed[$];
  out_t pending_samples[$];
  out_t want;

  int errors = 0;
  int cycles = 0;
  int transfers_in = 0;
  int samples_checked = 0;
  int notes_started = 0;
  int releases_done = 0;
  int rate_settings = 1;

  bit in_accepted = 0;
  int burst_left = 1;
  int gap_left = 0;
  bit hold_req = 0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int mode_left = 0;

  function automatic logic [63:0] fx30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // quarter-wave magnitude at table position 0..256
  function automatic logic [31:0] sine_at(input logic [8:0] pos);
    logic [63:0] x, xx, s;
    x  = fx30(64'(pos) << 22, Q30_HALF_PI);
    xx = fx30(x, x);
    s  = Q30_ONE - xx / 110;
    s  = Q30_ONE - fx30(xx / 72, s);
    s  = Q30_ONE - fx30(xx / 42, s);
    s  = Q30_ONE - fx30(xx / 20, s);
    s  = Q30_ONE - fx30(xx / 6, s);
    s  = fx30(x, s);
    return 32'((s * PEAK + (Q30_ONE >> 1)) >> 30);
  endfunction

  function automatic logic [31:0] step_for(input logic [6:0] note, input logic [17:0] rate);
    logic [127:0] num, den;
    num = 128'(SEMI_Q16[note % 12]) << (note / 12);
    den = 128'((rate == 18'd0) ? 18'd1 : rate) << 21;
    return 32'((num << 32) / den);
  endfunction

  task automatic predict_voice(input in_t it);
    logic [9:0]  idx;
    logic [8:0]  pos;
    logic [31:0] mag;
    out_t        res;
    case (it.kind)
      KIND_ON: begin
        voice_phase = '0;
        tail_q16 = '0;
        releasing = 1'b0;
        voice_level = 16'((32'(LEVEL_Q15) * it.note_velocity) / 127);
        voice_step = step_for(it.note_number, rate_hz);
        notes_started++;
      end
      KIND_OFF: begin
        if (it.allow_tail_off) begin
          if (!releasing) begin
            releasing = 1'b1;
            tail_q16 = 16'hFFFF;
          end
        end else begin
          voice_step = '0;
        end
      end
      KIND_TICK: begin
        res.sample_out = '0;
        if (voice_step != 0) begin
          idx = voice_phase[31:22];
          pos = idx[8] ? 9'd256 - {1'b0, idx[7:0]} : {1'b0, idx[7:0]};
          mag = (sine_at(pos) * voice_level) >> 15;
          if (releasing) mag = (mag * tail_q16) >> 16;
          res.sample_out = idx[9] ? 16'd0 - mag[15:0] : mag[15:0];
          voice_phase = voice_phase + voice_step;
          if (releasing) begin
            tail_q16 = 16'((32'(tail_q16) * DECAY) >> 16);
            if (tail_q16 <= RELEASE_FLOOR) begin
              voice_step = '0;
              releases_done++;
            end
          end
        end
        res.voice_active = (voice_step != 0);
        pending_samples.push_back(res);
      end
      default: ;
    endcase
  endtask

  // input acceptance feeds the predictor, then the output transfer is checked
  always @(posedge clk) begin
    in_accepted = !rst && in_valid && !in_stall;
    if (in_accepted) begin
      predict_voice(in_data);
      transfers_in++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample %0d active %0b", $time,
                 $signed(out_data.sample_out), out_data.voice_active);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (out_data.sample_out !== want.sample_out) begin
          errors++;
          $display("%0t: sample_out expected %0d got %0d", $time,
                   $signed(want.sample_out), $signed(out_data.sample_out));
        end
        if (out_data.voice_active !== want.voice_active) begin
          errors++;
          $display("%0t: voice_active expected %0b got %0b", $time,
                   want.voice_active, out_data.voice_active);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // sender: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_feed.size() > 0) begin
        in_data <= item_feed.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 4))
            0, 1: gap_left = 0;
            2, 3: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 30);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall modes, each held for a random span; one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= !out_stall;
      endcase
    end
  end

  task automatic offer(input logic [1:0] kind, input int note, input int vel, input int tail);
    in_t it;
    it.kind = kind;
    it.note_number = 7'(note);
    it.note_velocity = 7'(vel);
    it.allow_tail_off = 1'(tail);
    item_feed.push_back(it);
  endtask

  task automatic offer_ticks(input int n);
    repeat (n) offer(KIND_TICK, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 1));
  endtask

  // note phrases with random content, plus some raw noise
  task automatic queue_phrases(input int count);
    int made, n, vel;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
              $urandom_range(0, 1));
        made++;
      end else begin
        vel = $urandom_range(0, 127);
        if ($urandom_range(0, 7) == 0) vel = $urandom_range(0, 1) ? 127 : 0;
        offer(KIND_ON, $urandom_range(0, 127), vel, $urandom_range(0, 1));
        n = $urandom_range(1, 10);
        offer_ticks(n);
        made += n + 1;
        if ($urandom_range(0, 3) != 0) begin
          offer(KIND_OFF, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 9) < 7);
          n = $urandom_range(0, 14);
          offer_ticks(n);
          made += n + 1;
          if ($urandom_range(0, 3) == 0) begin
            offer(KIND_OFF, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 1));
            n = $urandom_range(0, 4);
            offer_ticks(n);
            made += n + 1;
          end
        end
      end
    end
  endtask

  task automatic settle();
    while (item_feed.size() != 0 || in_valid) @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate(input logic [31:0] value);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_SAMPLE_RATE;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    rate_hz = value[17:0];
    rate_settings++;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[17:0] !== rate_hz) begin
      errors++;
      $display("%0t: sample_rate readback expected %0d got %0d", $time, rate_hz, got[17:0]);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // silent voice, release armed on silence, unused kind
    offer(KIND_TICK, 0, 0, 0);
    offer(KIND_UNUSED, 127, 127, 1);
    offer(KIND_OFF, 0, 0, 1);
    offer(KIND_TICK, 127, 127, 1);
    // lowest note full velocity, then highest note zero velocity
    offer(KIND_ON, 0, 127, 0);
    offer_ticks(3);
    offer(KIND_ON, 127, 0, 1);
    offer_ticks(2);
    // release, repeated release ignored, hard stop, silent tick
    offer(KIND_ON, 69, 127, 0);
    offer_ticks(2);
    offer(KIND_OFF, 69, 0, 1);
    offer_ticks(2);
    offer(KIND_OFF, 69, 0, 1);
    offer_ticks(1);
    offer(KIND_OFF, 69, 0, 0);
    offer_ticks(1);
    offer(KIND_ON, 64, 64, 0);
    offer_ticks(1);
    queue_phrases(50);
    settle();

    // zero rate: step wraps to zero for the top A
    set_rate(32'd0);
    offer(KIND_ON, 117, 127, 0);
    offer_ticks(2);
    queue_phrases(30);
    settle();

    set_rate(32'd1);
    offer(KIND_ON, 33, 100, 0);
    offer_ticks(2);
    queue_phrases(30);
    settle();

    set_rate(32'h3FFFF);
    queue_phrases(40);
    settle();

    // long output hold while the sender keeps offering
    set_rate(32'd8000);
    hold_req = 1;
    queue_phrases(80);
    settle();

    // one release decays all the way to the end of the note
    set_rate(32'd192000);
    offer(KIND_ON, 81, 127, 0);
    offer_ticks(4);
    offer(KIND_OFF, 81, 127, 1);
    offer_ticks(560);
    queue_phrases(30);
    settle();

    set_rate(32'($urandom_range(8000, 192000)));
    queue_phrases(50);
    settle();

    $display("%0d transfers in, %0d samples checked, %0d notes, %0d full releases",
             transfers_in, samples_checked, notes_started, releases_done);
    $display("%0d sample-rate settings including 0, 1, 8000, 192000 and full scale",
             rate_settings);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sine_voice_with_tail_off.f @@
rtl/svt_pkg.sv
rtl/svt_seq.sv
rtl/sine_voice_with_tail_off.sv
rtl/svt_chk.sv
tb/tb_sine_voice_with_tail_off.sv
